/* rtl/fpu_regfile_csr_compare_unit_core_assert.svh */
// Assertion macros for the floating-point register file and compare unit
`ifndef FPU_REGFILE_CSR_COMPARE_UNIT_CORE_ASSERT_SVH
`define FPU_REGFILE_CSR_COMPARE_UNIT_CORE_ASSERT_SVH
`define FRC_ASSERT_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define FRC_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

/* rtl/frc_pkg.sv */
// Package: constants, opcodes and helpers of the FP register file and compare unit
package frc_pkg;
   localparam int RegCountDefault = 32;
   localparam logic [3:0] OP_WR32 = 4'd0;
   localparam logic [3:0] OP_WR64 = 4'd1;
   localparam logic [3:0] OP_RD32 = 4'd2;
   localparam logic [3:0] OP_RD64 = 4'd3;
   localparam logic [3:0] OP_CTLWR = 4'd4;
   localparam logic [3:0] OP_CTLRD = 4'd5;
   localparam logic [3:0] OP_CMP = 4'd6;
   localparam logic [3:0] OP_BRANCH = 4'd7;
   localparam logic [1:0] CSR_ENABLE = 2'd0;
   localparam logic [1:0] CSR_FULLREG = 2'd1;
   localparam logic [1:0] CSR_REVISION = 2'd2;
   localparam logic [1:0] CSR_IMPL = 2'd3;
   localparam logic [1:0] EXC_NONE = 2'd0;
   localparam logic [1:0] EXC_UNUSABLE = 2'd1;
   localparam logic [1:0] EXC_FPE = 2'd2;
   localparam logic [1:0] BR_NONE = 2'd0;
   localparam logic [1:0] BR_TAKEN = 2'd1;
   localparam logic [1:0] BR_NOT_TAKEN = 2'd2;
   localparam logic [1:0] BR_DISCARD = 2'd3;
   localparam logic [4:0] CTL_ID = 5'd0;
   localparam logic [4:0] CTL_CSR = 5'd31;
   localparam int ReqWidth = 168;
   localparam int RspWidth = 136;

   typedef struct packed {
      logic [3:0]  opcode;
      logic [4:0]  first_reg;
      logic [4:0]  second_reg;
      logic [3:0]  compare_cond;
      logic        is_double;
      logic [63:0] write_data;
      logic        branch_sense;
      logic        branch_likely;
      logic [15:0] branch_offset;
      logic [63:0] program_counter;
   } req_type;

   typedef struct packed {
      logic [63:0] read_data;
      logic [1:0]  branch_action;
      logic [63:0] branch_target;
      logic [1:0]  exception_code;
      logic        condition_out;
   } rsp_type;

   typedef struct packed {
      logic [1:0] lt_eq_nan;
   } unused_type;

   function automatic logic [2:0] cmp32(input logic [31:0] a, input logic [31:0] b);
      logic nan, eq, lt, az, bz;
      nan = (&a[30:23] && |a[22:0]) || (&b[30:23] && |b[22:0]);
      az = ~|a[30:0];
      bz = ~|b[30:0];
      eq = !nan && ((a == b) || (az && bz));
      if (nan || eq) lt = 1'b0;
      else if (a[31] != b[31]) lt = a[31];
      else if (a[31]) lt = a[30:0] > b[30:0];
      else lt = a[30:0] < b[30:0];
      return {nan, eq, lt};
   endfunction

   function automatic logic [2:0] cmp64(input logic [63:0] a, input logic [63:0] b);
      logic nan, eq, lt, az, bz;
      nan = (&a[62:52] && |a[51:0]) || (&b[62:52] && |b[51:0]);
      az = ~|a[62:0];
      bz = ~|b[62:0];
      eq = !nan && ((a == b) || (az && bz));
      if (nan || eq) lt = 1'b0;
      else if (a[63] != b[63]) lt = a[63];
      else if (a[63]) lt = a[62:0] > b[62:0];
      else lt = a[62:0] < b[62:0];
      return {nan, eq, lt};
   endfunction
endpackage

/* rtl/frc_regmem.sv */
// Register file memory: two read ports with registered data, one write port
module frc_regmem #(
   parameter int REG_COUNT = frc_pkg::RegCountDefault,
   parameter int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [63:0]   wr_data,
   input  logic [AW-1:0] rd_addr_a,
   input  logic [AW-1:0] rd_addr_b,
   output logic [63:0]   rd_data_a,
   output logic [63:0]   rd_data_b
);
   logic [63:0] mem [REG_COUNT];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule

/* rtl/fpu_regfile_csr_compare_unit_core.sv */
// Top level: FP register file, control/status word and compare unit
// Flow: the register file is read at the edge that accepts the req beat; the beat
// executes once no rsp beat is held, and rsp_tvalid rises when its result is registered.
// One beat at a time: req_tready is low while a beat is in flight, so a new beat is taken
// only after the last one executes; a held rsp beat (rsp_tready low) delays the execute step.
// Reset: synchronous; sets enable, clears other config, control/status and handshake state; registers undefined.
module fpu_regfile_csr_compare_unit_core #(
   parameter int REG_COUNT = frc_pkg::RegCountDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode, first_reg, second_reg, compare_cond, is_double, write_data,
   // branch_sense, branch_likely, branch_offset, program_counter
   input  logic [167:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // read_data, branch_action, branch_target, exception_code, condition_out
   output logic [135:0] rsp_tdata,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_wdata
);
   localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

   logic enable_ff, fullreg_ff;
   logic [7:0] rev_ff, impl_ff;
   logic [1:0] rmode_ff;
   logic [4:0] sticky_ff, traps_ff;
   logic [5:0] cause_ff;
   logic cond_ff, flush_ff;
   logic busy_ff, busy_in;
   logic exec;
   logic [167:0] rq_ff;
   logic rvalid_ff;
   logic [135:0] rdata_ff;

   logic [3:0] opcode;
   logic [4:0] fs, ft;
   logic [3:0] ccond;
   logic dbl;
   logic [63:0] wdata, pc;
   logic sense, likely;
   logic [15:0] off;

   always_comb begin
      opcode = rq_ff[3:0];
      fs = rq_ff[8:4];
      ft = rq_ff[13:9];
      ccond = rq_ff[17:14];
      dbl = rq_ff[18];
      wdata = rq_ff[82:19];
      sense = rq_ff[83];
      likely = rq_ff[84];
      off = rq_ff[100:85];
      pc = rq_ff[164:101];
   end

   function automatic logic [4:0] phys(input logic [4:0] idx, input logic full);
      return full ? idx : {idx[4:1], 1'b0};
   endfunction

   logic [4:0] req_pa, req_pb;
   always_comb begin
      req_pa = phys(req_tdata[8:4], fullreg_ff);
      req_pb = phys(req_tdata[13:9], fullreg_ff);
   end

   logic [4:0] pa, pb;
   logic va, vb;
   always_comb begin
      pa = phys(fs, fullreg_ff);
      pb = phys(ft, fullreg_ff);
      va = {1'b0, pa} < 6'(REG_COUNT);
      vb = {1'b0, pb} < 6'(REG_COUNT);
   end

   logic [4:0] rd_pa, rd_pb;
   always_comb begin
      rd_pa = busy_ff ? pa : req_pa;
      rd_pb = busy_ff ? pb : req_pb;
   end

   logic mem_we;
   logic [63:0] mem_wd, ma, mb;
   frc_regmem #(.REG_COUNT(REG_COUNT), .AW(AW)) u_mem (
      .clock(clock), .wr_en(mem_we), .wr_addr(pa[AW-1:0]), .wr_data(mem_wd),
      .rd_addr_a(rd_pa[AW-1:0]), .rd_addr_b(rd_pb[AW-1:0]),
      .rd_data_a(ma), .rd_data_b(mb)
   );

   logic hi;
   logic [63:0] ra, rb;
   logic [31:0] a32, b32;
   logic [2:0] c32, c64, cr;
   assign hi = !fullreg_ff && fs[0];
   always_comb begin
      ra = va ? ma : 64'd0;
      rb = vb ? mb : 64'd0;
      a32 = hi ? ra[63:32] : ra[31:0];
      b32 = (!fullreg_ff && ft[0]) ? rb[63:32] : rb[31:0];
      c32 = frc_pkg::cmp32(a32, b32);
      c64 = frc_pkg::cmp64(ra, rb);
      cr = dbl ? c64 : c32;
   end

   logic [63:0] rd, tgt;
   logic [1:0] act, exc;
   logic cond_n, flush_n;
   logic [1:0] rmode_n;
   logic [4:0] sticky_n, traps_n;
   logic [5:0] cause_n;
   logic [31:0] csrw;

   always_comb begin
      csrw = {7'd0, flush_ff, cond_ff, 5'd0, cause_ff, traps_ff, sticky_ff, rmode_ff};
      rd = '0; tgt = '0; act = frc_pkg::BR_NONE; exc = frc_pkg::EXC_NONE;
      cond_n = cond_ff; flush_n = flush_ff; rmode_n = rmode_ff;
      sticky_n = sticky_ff; traps_n = traps_ff; cause_n = cause_ff;
      mem_we = 1'b0; mem_wd = ra;
      if (!enable_ff) begin
         exc = frc_pkg::EXC_UNUSABLE;
      end else begin
         unique case (opcode)
            frc_pkg::OP_WR32: begin
               mem_we = exec && va;
               mem_wd = hi ? {wdata[31:0], ra[31:0]} : {ra[63:32], wdata[31:0]};
            end
            frc_pkg::OP_WR64: begin
               mem_we = exec && va;
               mem_wd = wdata;
            end
            frc_pkg::OP_RD32: rd = {{32{a32[31]}}, a32};
            frc_pkg::OP_RD64: rd = ra;
            frc_pkg::OP_CTLWR: begin
               if (fs == frc_pkg::CTL_CSR) begin
                  rmode_n = wdata[1:0];
                  sticky_n = wdata[6:2];
                  traps_n = wdata[11:7];
                  cause_n = wdata[17:12];
                  cond_n = wdata[23];
                  flush_n = wdata[24];
               end
            end
            frc_pkg::OP_CTLRD: begin
               if (fs == frc_pkg::CTL_ID) rd = {48'd0, impl_ff, rev_ff};
               else if (fs == frc_pkg::CTL_CSR) rd = {32'd0, csrw};
            end
            frc_pkg::OP_CMP: begin
               if (cr[2]) begin
                  if (ccond[3]) begin
                     cause_n = cause_ff | 6'h10;
                     if (traps_ff[4]) exc = frc_pkg::EXC_FPE;
                     else sticky_n = sticky_ff | 5'h10;
                  end
                  if (!(ccond[3] && traps_ff[4])) cond_n = ccond[0];
               end else begin
                  cond_n = (ccond[1] && cr[1]) || (ccond[2] && cr[0]);
               end
            end
            frc_pkg::OP_BRANCH: begin
               tgt = pc + 64'd4 + {{46{off[15]}}, off, 2'b00};
               if (cond_ff == sense) act = frc_pkg::BR_TAKEN;
               else act = likely ? frc_pkg::BR_DISCARD : frc_pkg::BR_NOT_TAKEN;
            end
            default: exc = frc_pkg::EXC_FPE;
         endcase
      end
   end

   assign exec = busy_ff && (!rvalid_ff || rsp_tready);
   assign req_tready = !busy_ff;
   assign busy_in = exec ? 1'b0 : (busy_ff || req_tvalid);

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) rq_ff <= req_tdata;
      if (exec) rdata_ff <= {3'd0, cond_n, exc, tgt, act, rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1; fullreg_ff <= 1'b0; rev_ff <= '0; impl_ff <= '0;
         rmode_ff <= '0; sticky_ff <= '0; traps_ff <= '0; cause_ff <= '0;
         cond_ff <= 1'b0; flush_ff <= 1'b0; busy_ff <= 1'b0; rvalid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (exec) rvalid_ff <= 1'b1;
         else if (rsp_tready) rvalid_ff <= 1'b0;
         if (exec) begin
            rmode_ff <= rmode_n; sticky_ff <= sticky_n; traps_ff <= traps_n;
            cause_ff <= cause_n; cond_ff <= cond_n; flush_ff <= flush_n;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               frc_pkg::CSR_ENABLE: enable_ff <= csr_wdata[0];
               frc_pkg::CSR_FULLREG: fullreg_ff <= csr_wdata[0];
               frc_pkg::CSR_REVISION: rev_ff <= csr_wdata;
               frc_pkg::CSR_IMPL: impl_ff <= csr_wdata;
            endcase
         end
      end
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata = rdata_ff;
endmodule

/* rtl/frc_checker.sv */
// Port-level assertions for the FP register file and compare unit
`include "fpu_regfile_csr_compare_unit_core_assert.svh"
module frc_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata
);
   `FRC_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)
   `FRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `FRC_ASSERT_IMPL(a_exc_range, clock, reset, rsp_tvalid, rsp_tdata[131:130] != 2'd3)
   `FRC_ASSERT_IMPL(a_branch_only, clock, reset, rsp_tvalid && rsp_tdata[65:64] != 2'd0, rsp_tdata[63:0] == 64'd0)
endmodule

bind fpu_regfile_csr_compare_unit_core frc_checker u_frc_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
